### hw/rtl/ntcu_pkg.sv
// ntcu_pkg: cast kind codes and field widths for the numeric type cast unit
// no dependencies
package ntcu_pkg;

   localparam int DataWidth = 64;
   localparam int KindWidth = 4;

   typedef enum logic [KindWidth-1:0] {
      KIND_I16_F32 = 4'd0,
      KIND_I16_F64 = 4'd1,
      KIND_I16_I32 = 4'd2,
      KIND_I16_I64 = 4'd3,
      KIND_I32_I16 = 4'd4,
      KIND_I32_F32 = 4'd5,
      KIND_I32_F64 = 4'd6,
      KIND_I32_I64 = 4'd7,
      KIND_I64_I16 = 4'd8,
      KIND_I64_I32 = 4'd9,
      KIND_I64_F64 = 4'd10,
      KIND_F32_F64 = 4'd11,
      KIND_F32_I64 = 4'd12
   } cast_kind_type;

   localparam logic [2:0] REG_CAST_KIND = 3'd0;

endpackage

### hw/rtl/numeric_type_cast_unit.sv
// numeric_type_cast_unit: integer / float element conversion, one item per cycle when not stalled
// depends on ntcu_pkg
//
// Each accepted item is held in an input register, converted by combinational
// logic (sign extension, leading-one search, round to nearest even, float
// rebias) and captured in a result register. One item a cycle is accepted
// and one result a cycle is delivered while the output is not stalled; each
// item moves from the input register to the result register, which drives
// rsp_valid. The input register refills whenever it is empty or the result
// register is free or being taken, so a stalled result holds both stages.
// cast_kind is written at csr address 0 and selects the conversion: 0..3
// int16 to float, double, int32, int64; 4..7 int32 to int16, float, double,
// int64; 8..10 int64 to int16, int32, double; 11 float to double; 12 float
// to int64 (truncates, saturates, flags NaN or overflow on rsp_invalid). Unknown kinds give zero.
module numeric_type_cast_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_source_bits,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_bits,
   output logic        rsp_invalid,
   output logic        rsp_last_out,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ntcu_pkg::*;

   logic [3:0]  kind_ff;
   logic        s1_valid_ff, s2_valid_ff;
   logic [63:0] s1_src_ff, s2_res_ff;
   logic        s1_last_ff, s2_last_ff, s2_bad_ff;
   logic        s2_free, s1_free, req_fire;

   // config port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_CAST_KIND) ? {28'd0, kind_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= 4'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == REG_CAST_KIND) begin
         kind_ff <= csr_pwdata[3:0];
      end
   end

   // handshake between stages
   assign s2_free   = !s2_valid_ff || !rsp_stall;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;
   assign req_fire  = req_valid && s1_free;

   // leading-one position of a 64-bit value
   function automatic logic [5:0] msb_pos(input logic [63:0] v);
      logic [5:0] p;
      p = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) p = 6'(i);
      end
      return p;
   endfunction

   // int to float (mbits 23) or double (mbits 52), round to nearest even
   function automatic logic [63:0] int_to_fp(input logic [63:0] v, input logic dbl);
      logic        s;
      logic [63:0] mag, norm, sig, res;
      logic [5:0]  p;
      logic [6:0]  mb;
      logic        guard, sticky, up;
      logic [10:0] ex;
      s    = v[63];
      mag  = s ? (64'd0 - v) : v;
      p    = msb_pos(mag);
      mb   = dbl ? 7'd52 : 7'd23;
      // leading one to bit 63
      norm = mag << (6'd63 - p);
      if (dbl) begin
         sig    = {11'd0, norm[63:11]};
         guard  = norm[10];
         sticky = |norm[9:0];
      end else begin
         sig    = {40'd0, norm[63:40]};
         guard  = norm[39];
         sticky = |norm[38:0];
      end
      up  = guard && (sticky || sig[0]);
      sig = sig + {63'd0, up};
      ex  = {5'd0, p};
      if (sig[mb[5:0] + 6'd1]) begin
         sig = sig >> 1;
         ex  = ex + 11'd1;
      end
      if (dbl) begin
         res = {s, ex + 11'd1023, sig[51:0]};
      end else begin
         res = {32'd0, s, ex[7:0] + 8'd127, sig[22:0]};
      end
      if (mag == 64'd0) res = 64'd0;
      return res;
   endfunction

   function automatic logic [63:0] f32_to_f64(input logic [31:0] f);
      logic        s;
      logic [7:0]  e;
      logic [22:0] m;
      logic [5:0]  pf;
      logic [4:0]  p;
      logic [63:0] r;
      logic [52:0] sh;
      s = f[31];
      e = f[30:23];
      m = f[22:0];
      pf = msb_pos({41'd0, m});
      p = pf[4:0];
      sh = {30'd0, m} << (6'd52 - {1'b0, p});
      if (e == 8'hFF) begin
         r = (m == 23'd0) ? {s, 11'h7FF, 52'd0} : {s, 11'h7FF, 1'b1, m[21:0], 29'd0};
         if (m != 23'd0) r[50:29] = m[21:0];
         if (m != 23'd0) r[51] = 1'b1;
      end else if (e == 8'd0) begin
         r = (m == 23'd0) ? {s, 63'd0}
                          : {s, 11'd874 + {6'd0, p}, sh[51:0]};
      end else begin
         r = {s, {3'd0, e} + 11'd896, m, 29'd0};
      end
      return r;
   endfunction

   function automatic logic [64:0] f32_to_i64(input logic [31:0] f);
      logic        s;
      logic [7:0]  e;
      logic [22:0] m;
      logic [63:0] sig, mag;
      logic [64:0] r;
      s   = f[31];
      e   = f[30:23];
      m   = f[22:0];
      sig = {40'd0, 1'b1, m};
      mag = (e >= 8'd150) ? (sig << (e - 8'd150)) : (sig >> (8'd150 - e));
      if (e == 8'hFF && m != 23'd0) r = {1'b1, 64'd0};
      else if (e < 8'd127) r = 65'd0;
      else if (e >= 8'd190) begin
         if (s && e == 8'd190 && m == 23'd0) r = {1'b0, 1'b1, 63'd0};
         else r = {1'b1, s ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}};
      end else r = {1'b0, s ? (64'd0 - mag) : mag};
      return r;
   endfunction

   logic [63:0] x16, x32, res;
   logic [64:0] fi;
   logic        bad;

   assign x16 = {{48{s1_src_ff[15]}}, s1_src_ff[15:0]};
   assign x32 = {{32{s1_src_ff[31]}}, s1_src_ff[31:0]};
   assign fi  = f32_to_i64(s1_src_ff[31:0]);

   always_comb begin
      bad = 1'b0;
      case (kind_ff)
         KIND_I16_F32: res = int_to_fp(x16, 1'b0);
         KIND_I16_F64: res = int_to_fp(x16, 1'b1);
         KIND_I16_I32: res = {32'd0, x16[31:0]};
         KIND_I16_I64: res = x16;
         KIND_I32_I16: res = {48'd0, s1_src_ff[15:0]};
         KIND_I32_F32: res = int_to_fp(x32, 1'b0);
         KIND_I32_F64: res = int_to_fp(x32, 1'b1);
         KIND_I32_I64: res = x32;
         KIND_I64_I16: res = {48'd0, s1_src_ff[15:0]};
         KIND_I64_I32: res = {32'd0, s1_src_ff[31:0]};
         KIND_I64_F64: res = int_to_fp(s1_src_ff, 1'b1);
         KIND_F32_F64: res = f32_to_f64(s1_src_ff[31:0]);
         KIND_F32_I64: begin
            res = fi[63:0];
            bad = fi[64];
         end
         default: res = 64'd0;
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (s1_free) s1_valid_ff <= req_valid;
      if (req_fire) begin
         s1_src_ff  <= req_source_bits;
         s1_last_ff <= req_last_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (s2_free) s2_valid_ff <= s1_valid_ff;
      if (s2_free && s1_valid_ff) begin
         s2_res_ff  <= res;
         s2_bad_ff  <= bad;
         s2_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid       = s2_valid_ff;
   assign rsp_result_bits = s2_res_ff;
   assign rsp_invalid     = s2_bad_ff;
   assign rsp_last_out    = s2_last_ff;

   // a stalled result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_bits))
      else $error("result changed under stall");
   // invalid only from the float to int64 kind
   a_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> kind_ff == KIND_F32_I64)
      else $error("invalid flag on wrong kind");
   // input stage accepts only with room downstream
   a_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && rsp_stall |-> req_stall)
      else $error("accept while pipeline full");

endmodule

### verif/tb_top.sv
// tb_top: self-checking bench for numeric_type_cast_unit, random valid/stall traffic
// depends on ntcu_pkg and the numeric_type_cast_unit rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ntcu_pkg::*;

   typedef struct packed {
      logic [63:0] bits;
      logic        last;
   } src_item_type;

   typedef struct packed {
      logic [63:0] bits;
      logic        invalid;
      logic        last;
   } cast_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_source_bits = '0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_bits;
   logic        rsp_invalid;
   logic        rsp_last_out;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   numeric_type_cast_unit dut (.*);

   always #5 clock = ~clock;

   // predictor state: the kind the block is running
   logic [3:0]      cur_kind = '0;
   src_item_type    pending_src[$];
   cast_result_type expected_casts[$];
   int              mismatches = 0;
   int              unexpected = 0;
   int              accepted_in = 0;
   int              delivered = 0;
   int              idle_cycles = 0;
   bit              timed_out = 0;
   bit              calm = 0;       // no random idling while set
   int              hold_off = 0;   // long receiver hold-off, counted down below

   function automatic logic [63:0] sx16(logic [63:0] v);
      return {{48{v[15]}}, v[15:0]};
   endfunction

   function automatic logic [63:0] sx32(logic [63:0] v);
      return {{32{v[31]}}, v[31:0]};
   endfunction

   // signed integer to binary32 (mb=23) or binary64 (mb=52), nearest even
   function automatic logic [63:0] int_to_fp(logic [63:0] v, int mb, int bias, int total);
      logic [63:0] mag, sig, rem, half, res;
      int p, sh;
      mag = v[63] ? (64'd0 - v) : v;
      if (mag == 0) return 64'd0;
      p = 63;
      while (!mag[p]) p--;
      if (p <= mb) begin
         sig = mag << (mb - p);
      end else begin
         sh = p - mb;
         rem = mag & ((64'd1 << sh) - 1);
         half = 64'd1 << (sh - 1);
         sig = mag >> sh;
         if (rem > half || (rem == half && sig[0])) sig++;
         if (sig == (64'd1 << (mb + 1))) begin
            sig = sig >> 1;
            p++;
         end
      end
      res = (64'(p + bias) << mb) | (sig & ((64'd1 << mb) - 1));
      res[total-1] = v[63];
      return res;
   endfunction

   function automatic logic [63:0] widen_float(logic [31:0] f);
      logic [63:0] top;
      logic [63:0] m;
      int p;
      top = {f[31], 63'd0};
      m = {41'd0, f[22:0]};
      if (f[30:23] == 8'hFF) begin
         if (m == 0) return top | (64'h7FF << 52);
         return top | (64'h7FF << 52) | (64'd1 << 51) | (m << 29);
      end
      if (f[30:23] == 0) begin
         if (m == 0) return top;
         p = 22;
         while (!m[p]) p--;
         return top | (64'(p + 1023 - 149) << 52) | ((m << (52 - p)) & 64'hF_FFFF_FFFF_FFFF);
      end
      return top | (64'(f[30:23] + 1023 - 127) << 52) | (m << 29);
   endfunction

   function automatic logic [64:0] float_to_i64(logic [31:0] f);
      int e;
      logic [63:0] sig, mag;
      e = f[30:23];
      if (e == 255 && f[22:0] != 0) return {1'b1, 64'd0};
      if (e < 127) return 65'd0;
      if (e >= 190) begin
         if (f[31] && e == 190 && f[22:0] == 0) return {1'b0, 64'h8000_0000_0000_0000};
         return f[31] ? {1'b1, 64'h8000_0000_0000_0000} : {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
      end
      sig = {40'd0, 1'b1, f[22:0]};
      mag = (e >= 150) ? (sig << (e - 150)) : (sig >> (150 - e));
      return {1'b0, f[31] ? (64'd0 - mag) : mag};
   endfunction

   function automatic cast_result_type cast_element(logic [3:0] kind, src_item_type s);
      cast_result_type r;
      logic [64:0] fi;
      r.bits = '0;
      r.invalid = 1'b0;
      r.last = s.last;
      case (kind)
         KIND_I16_F32: r.bits = int_to_fp(sx16(s.bits), 23, 127, 32);
         KIND_I16_F64: r.bits = int_to_fp(sx16(s.bits), 52, 1023, 64);
         KIND_I16_I32: r.bits = sx16(s.bits) & 64'hFFFF_FFFF;
         KIND_I16_I64: r.bits = sx16(s.bits);
         KIND_I32_I16: r.bits = {48'd0, s.bits[15:0]};
         KIND_I32_F32: r.bits = int_to_fp(sx32(s.bits), 23, 127, 32);
         KIND_I32_F64: r.bits = int_to_fp(sx32(s.bits), 52, 1023, 64);
         KIND_I32_I64: r.bits = sx32(s.bits);
         KIND_I64_I16: r.bits = {48'd0, s.bits[15:0]};
         KIND_I64_I32: r.bits = {32'd0, s.bits[31:0]};
         KIND_I64_F64: r.bits = int_to_fp(s.bits, 52, 1023, 64);
         KIND_F32_F64: r.bits = widen_float(s.bits[31:0]);
         KIND_F32_I64: begin
            fi = float_to_i64(s.bits[31:0]);
            r.bits = fi[63:0];
            r.invalid = fi[64];
         end
         default: r.bits = '0;
      endcase
      return r;
   endfunction

   // driver: pops the next item, holds it until accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_casts.push_back(cast_element(cur_kind,
               '{bits: req_source_bits, last: req_last_in}));
            accepted_in++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_src.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
               src_item_type nx;
               nx = pending_src.pop_front();
               req_valid <= 1'b1;
               req_source_bits <= nx.bits;
               req_last_in <= nx.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each delivered item against the oldest prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            delivered++;
            if (expected_casts.size() == 0) begin
               unexpected++;
               if (mismatches + unexpected <= 10)
                  $display("unexpected item: bits=%h inv=%b last=%b",
                           rsp_result_bits, rsp_invalid, rsp_last_out);
            end else begin
               cast_result_type w;
               w = expected_casts.pop_front();
               if (w.bits !== rsp_result_bits || w.invalid !== rsp_invalid ||
                   w.last !== rsp_last_out) begin
                  mismatches++;
                  if (mismatches + unexpected <= 10)
                     $display("mismatch kind=%0d: exp %h/%b/%b got %h/%b/%b", cur_kind,
                              w.bits, w.invalid, w.last,
                              rsp_result_bits, rsp_invalid, rsp_last_out);
               end
            end
         end
         // receiver stall: long hold-off when asked, else random idling
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 20);
         end
      end
   end

   // watchdog: counts cycles with no handshake on either channel and no receiver hold-off
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || hold_off > 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         timed_out = 1;
         $display("watchdog expired");
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      cur_kind = data[3:0];
   endtask

   // wait until the block has drained
   task automatic drain();
      while (pending_src.size() > 0 || req_valid || expected_casts.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // random source element biased toward interesting values for the kind
   function automatic logic [63:0] pick_source(logic [3:0] kind);
      logic [63:0] v;
      int sel;
      v = rand64();
      sel = $urandom_range(9);
      if (kind == KIND_F32_I64 || kind == KIND_F32_F64) begin
         // exponent near the int64 edge, subnormals, inf and nan
         case (sel)
            0: v[30:23] = 8'd190;
            1: v[30:23] = 8'd0;
            2: v[30:23] = 8'hFF;
            3, 4: v[30:23] = 8'($urandom_range(120, 195));
            default: ;
         endcase
      end else if (sel < 3) begin
         v = v >> $urandom_range(63);
         if (sel == 0) v = -v;
      end
      return v;
   endfunction

   task automatic push_src(logic [63:0] b, logic l);
      pending_src.push_back('{bits: b, last: l});
   endtask

   localparam logic [63:0] DIRECTED[15] = '{
      64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF, 64'h8000, 64'h7FFF_FFFF,
      64'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'h0000_0000_7F80_0000, 64'h0000_0000_FF80_0000, 64'h0000_0000_7FC0_0001,
      64'h0000_0000_0000_0001, 64'h0000_0000_DF00_0000, 64'h0000_0000_5F00_0000,
      64'h0100_0001_0100_0001
   };

   int kinds_seen = 0;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // reset kind first, then every kind with directed corner values
      for (int k = 0; k < 16; k++) begin
         if (k > 0) csr_write(REG_CAST_KIND, 32'(k) | 32'hFFFF_FFF0 & {32{k[0]}});
         foreach (DIRECTED[i]) push_src(DIRECTED[i], i[0]);
         drain();
         kinds_seen++;
      end
      // random phases, one kind each, extremes included
      for (int ph = 0; ph < 24; ph++) begin
         int k;
         k = (ph == 0) ? 0 : (ph == 1) ? 15 : (ph % 3 == 0) ? 12 : $urandom_range(15);
         csr_write(REG_CAST_KIND, 32'(k));
         calm = (ph == 5);
         for (int n = 0; n < 60; n++) push_src(pick_source(k[3:0]), 1'($urandom_range(1)));
         if (ph == 7) begin
            // let the sender run ahead while the receiver holds off
            hold_off = 60;
         end
         drain();
         kinds_seen++;
      end
      calm = 0;
      repeat (10) @(posedge clock);
      $display("ran %0d phases across all cast kinds: %0d items in, %0d items out",
               kinds_seen, accepted_in, delivered);
      if (mismatches == 0 && unexpected == 0 && expected_casts.size() == 0 && !timed_out)
         $display("== PASS ==");
      else begin
         $display("%0d mismatches, %0d unexpected, %0d missing",
                  mismatches, unexpected, expected_casts.size());
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
